### rtl/gdr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdr_pkg: shared types for the grid ray caster
// Item structs, command codes and the controller state encoding.
// ----------------------------------------------------------------------------
package gdr_pkg;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST  = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [5:0]         tile_x;
    logic [5:0]         tile_y;
    logic [7:0]         tile_value;
    logic [21:0]        pos_x;
    logic [21:0]        pos_y;
    logic signed [19:0] dir_x;
    logic signed [19:0] dir_y;
  } gdr_in_t;

  typedef struct packed {
    logic [5:0]  hit_x;
    logic [5:0]  hit_y;
    logic        hit_side;
    logic [23:0] distance;
    logic        outside;
  } gdr_out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y,
    ST_MUL_X,
    ST_MUL_Y,
    ST_STEP,
    ST_READ,
    ST_TEST,
    ST_DONE
  } gdr_state_t;

endpackage
`default_nettype wire

### rtl/grid_dda_ray_cast_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grid_dda_ray_cast_unit: tile map with a DDA grid ray caster
// Tile writes and ray casts on one valid/ready input channel.
// ----------------------------------------------------------------------------
// A write goes to the map as it is accepted. A cast first forms the two step
// lengths with a shared radix-2 divider, one axis after the other, then the two
// first boundary distances, then walks the grid cell by cell in three steps set
// by the single map port: step, read, test. After reset the map is cleared one
// tile per cycle, during which no item is accepted. One item is in work at a
// time; the result sits in an output register while the next item is accepted.
// ----------------------------------------------------------------------------
module grid_dda_ray_cast_unit #(
  parameter int MAP_WIDTH  = 64,
  parameter int MAP_HEIGHT = 64,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire gdr_pkg::gdr_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output gdr_pkg::gdr_out_t      out_data
);
  import gdr_pkg::*;

  localparam int XW    = $clog2(MAP_WIDTH);
  localparam int YW    = $clog2(MAP_HEIGHT);
  localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = FRAC_BITS + 8;
  localparam int CW    = 12;                 // signed cell coordinate
  localparam int NUMW  = 2 * FRAC_BITS + 1;  // numerator 2^(2F)
  localparam int DIVC  = $clog2(NUMW + 1);
  localparam logic [DW-1:0] DIST_MAX = {DW{1'b1}};

  gdr_state_t state, state_next;

  logic [AW-1:0]   clr_addr;
  logic [21:0]     px, py;
  logic            nx, ny;
  logic [19:0]     mx, my;
  logic [DW-1:0]   dx, dy, tx, ty, hit_dist;
  logic signed [CW-1:0] cx, cy;
  logic            side;
  logic [NUMW-1:0] quo;
  logic [20:0]     rem;
  logic [DIVC-1:0] div_cnt;
  gdr_out_t        res;
  logic            res_pend;

  // map port
  logic            ram_we;
  logic [AW-1:0]   ram_addr;
  logic [7:0]      ram_wdata, ram_rdata;

  gdr_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_map (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  wire in_xfer  = in_valid && in_ready;
  wire out_xfer = out_valid && out_ready;
  wire wr_ok    = (32'(in_data.tile_x) < MAP_WIDTH) && (32'(in_data.tile_y) < MAP_HEIGHT);

  function automatic logic in_map(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
    return (x >= 0) && (32'(x) < MAP_WIDTH) && (y >= 0) && (32'(y) < MAP_HEIGHT);
  endfunction

  function automatic logic [DW-1:0] sat_add(logic [DW-1:0] a, logic [DW-1:0] b);
    logic [DW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DW] ? DIST_MAX : s[DW-1:0];
  endfunction

  // DDA step decision
  wire lt  = tx < ty;
  wire gt  = tx > ty;
  wire stx = !gt;
  wire sty = !lt;
  wire logic signed [CW-1:0] cx_n = stx ? (nx ? cx - 12'sd1 : cx + 12'sd1) : cx;
  wire logic signed [CW-1:0] cy_n = sty ? (ny ? cy - 12'sd1 : cy + 12'sd1) : cy;

  // divider: one quotient bit per cycle, numerator 2^(2F)
  wire [19:0] div_d   = (state == ST_DIV_X) ? mx : my;
  wire [DIVC-1:0] bitn = DIVC'(NUMW - 1) - div_cnt;
  wire        num_bit = (32'(bitn) == 2 * FRAC_BITS);
  wire [21:0] rsh     = {rem, num_bit};
  wire        ge      = rsh >= {2'b00, div_d};
  wire [NUMW-1:0] quo_n = {quo[NUMW-2:0], ge};
  wire        div_last = (32'(div_cnt) == NUMW - 1);
  wire [DW-1:0] step_sat = (div_d == 20'd0 || |quo_n[NUMW-1:DW]) ? DIST_MAX : quo_n[DW-1:0];

  // first boundary distance
  wire        mul_x   = (state == ST_MUL_X);
  wire [FRAC_BITS-1:0] frac = mul_x ? px[FRAC_BITS-1:0] : py[FRAC_BITS-1:0];
  wire        fneg    = mul_x ? nx : ny;
  wire [FRAC_BITS:0] part = fneg ? {1'b0, frac} : ((FRAC_BITS+1)'(1) << FRAC_BITS) - {1'b0, frac};
  wire [DW+FRAC_BITS:0] prod = part * (mul_x ? dx : dy);
  wire [DW:0] prod_sh = prod[DW+FRAC_BITS:FRAC_BITS];
  wire [DW-1:0] first_sat = prod_sh[DW] ? DIST_MAX : prod_sh[DW-1:0];

  wire [AW-1:0] cell_addr = AW'(32'(cy[YW:0]) * MAP_WIDTH + 32'(cx[XW:0]));

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_addr   = cell_addr;
    ram_wdata  = in_data.tile_value;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_addr;
        ram_wdata = 8'd0;
        if (32'(clr_addr) == DEPTH - 1) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        ram_addr = AW'(32'(in_data.tile_y) * MAP_WIDTH + 32'(in_data.tile_x));
        if (in_valid && in_ready && in_data.cmd == CMD_WRITE) begin
          ram_we = wr_ok;
        end else if (in_xfer) begin
          state_next = (in_map(CW'(in_data.pos_x[21:FRAC_BITS]),
                               CW'(in_data.pos_y[21:FRAC_BITS]))) ? ST_DIV_X : ST_DONE;
        end
      end
      ST_DIV_X: if (div_last) state_next = ST_DIV_Y;
      ST_DIV_Y: if (div_last) state_next = ST_MUL_X;
      ST_MUL_X: state_next = ST_MUL_Y;
      ST_MUL_Y: state_next = ST_STEP;
      ST_STEP:  state_next = in_map(cx_n, cy_n) ? ST_READ : ST_DONE;
      ST_READ:  state_next = ST_TEST;
      ST_TEST:  state_next = (ram_rdata != 8'd0) ? ST_DONE : ST_STEP;
      ST_DONE:  if (!res_pend || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      res_pend <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (state == ST_DONE && (!res_pend || out_ready)) res_pend <= 1'b1;
      else if (out_xfer) res_pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: if (in_xfer) begin
        px       <= in_data.pos_x;
        py       <= in_data.pos_y;
        nx       <= in_data.dir_x[19];
        ny       <= in_data.dir_y[19];
        mx       <= in_data.dir_x[19] ? 20'(-in_data.dir_x) : 20'(in_data.dir_x);
        my       <= in_data.dir_y[19] ? 20'(-in_data.dir_y) : 20'(in_data.dir_y);
        cx       <= CW'(in_data.pos_x[21:FRAC_BITS]);
        cy       <= CW'(in_data.pos_y[21:FRAC_BITS]);
        side     <= 1'b0;
        hit_dist <= '0;
        rem      <= '0;
        quo      <= '0;
        div_cnt  <= '0;
      end
      ST_DIV_X, ST_DIV_Y: begin
        rem     <= ge ? 21'(rsh - {2'b00, div_d}) : rsh[20:0];
        quo     <= quo_n;
        div_cnt <= div_last ? '0 : div_cnt + 1'b1;
        if (div_last) begin
          rem <= '0;
          quo <= '0;
          if (state == ST_DIV_X) dx <= step_sat;
          else                   dy <= step_sat;
        end
      end
      ST_MUL_X: tx <= first_sat;
      ST_MUL_Y: ty <= first_sat;
      ST_STEP: begin
        hit_dist <= lt ? tx : (gt ? ty : tx);
        side     <= gt;
        if (stx) tx <= sat_add(tx, dx);
        if (sty) ty <= sat_add(ty, dy);
        cx <= cx_n;
        cy <= cy_n;
      end
      default: ;
    endcase
    if (state == ST_DONE && (!res_pend || out_ready)) begin
      res.hit_x    <= 6'(cx);
      res.hit_y    <= 6'(cy);
      res.hit_side <= side;
      res.distance <= 24'(hit_dist);
      res.outside  <= !in_map(cx, cy);
    end
  end

  assign out_valid = res_pend;
  assign out_data  = res;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready) else $error("input taken while busy");
  a_cast_reads_in_map: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> in_map(cx, cy)) else $error("map read outside map");
  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !out_valid) else $error("result during clear");
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result dropped");
`endif

endmodule
`default_nettype wire

### rtl/gdr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdr_ram: generic single port RAM
// One write or read per cycle, read data registered.
// ----------------------------------------------------------------------------
module gdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

### tb/tb_grid_dda_ray_cast_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_dda_ray_cast_unit: self-checking bench for the grid ray caster
// Loads tile maps, casts directed and random rays and compares every hit
// against a DDA predictor kept in the bench, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_grid_dda_ray_cast_unit;
  import gdr_pkg::*;

  localparam int        MAP_DIM   = 64;
  localparam int        FRAC      = 16;
  localparam logic [63:0] DIST_SAT = (64'd1 << (FRAC + 8)) - 1;
  localparam logic [63:0] ONE_FX   = 64'd1 << FRAC;
  localparam int        IDLE_LIMIT = 20000;
  localparam int        N_RANDOM   = 1350;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  gdr_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  gdr_out_t out_data;

  grid_dda_ray_cast_unit u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [7:0] tiles [MAP_DIM*MAP_DIM];
  gdr_out_t   hit_queue [$];
  int         errors = 0;
  int         casts_sent = 0;
  int         writes_sent = 0;
  int         hits_seen = 0;
  int         outside_seen = 0;
  int         idle_cycles = 0;
  bit         long_stall = 1'b0;

  function automatic logic [63:0] sat_d(logic [63:0] v);
    return (v > DIST_SAT) ? DIST_SAT : v;
  endfunction

  function automatic logic [63:0] step_length(logic [19:0] mag);
    if (mag == 0) return DIST_SAT;
    return sat_d((64'd1 << (2*FRAC)) / mag);
  endfunction

  function automatic gdr_out_t cast_ray(gdr_in_t it);
    gdr_out_t   r;
    int         cx, cy, sx, sy;
    bit         nx, ny, gone, done;
    logic [19:0] mx, my;
    logic [63:0] dx, dy, tx, ty, hit_dist, fx, fy;
    logic        side;
    cx = int'(it.pos_x >> FRAC);
    cy = int'(it.pos_y >> FRAC);
    hit_dist = 0; side = 1'b0; gone = 1'b0;
    if (cx >= MAP_DIM || cy >= MAP_DIM) begin
      gone = 1'b1;
    end else begin
      nx = it.dir_x[19];
      ny = it.dir_y[19];
      mx = nx ? -it.dir_x : it.dir_x;
      my = ny ? -it.dir_y : it.dir_y;
      dx = step_length(mx);
      dy = step_length(my);
      fx = it.pos_x & (ONE_FX - 1);
      fy = it.pos_y & (ONE_FX - 1);
      tx = sat_d(((nx ? fx : ONE_FX - fx) * dx) >> FRAC);
      ty = sat_d(((ny ? fy : ONE_FX - fy) * dy) >> FRAC);
      sx = nx ? -1 : 1;
      sy = ny ? -1 : 1;
      done = 1'b0;
      while (!done) begin
        if (tx < ty) begin
          hit_dist = tx; tx = sat_d(tx + dx); cx += sx; side = 1'b0;
        end else if (tx > ty) begin
          hit_dist = ty; ty = sat_d(ty + dy); cy += sy; side = 1'b1;
        end else begin
          hit_dist = tx; tx = sat_d(tx + dx); ty = sat_d(ty + dy);
          cx += sx; cy += sy; side = 1'b0;
        end
        if (cx < 0 || cx >= MAP_DIM || cy < 0 || cy >= MAP_DIM) begin
          gone = 1'b1; done = 1'b1;
        end else if (tiles[cy*MAP_DIM + cx] != 0) begin
          done = 1'b1;
        end
      end
    end
    r.hit_x = cx[5:0];
    r.hit_y = cy[5:0];
    r.hit_side = side;
    r.distance = hit_dist[23:0];
    r.outside = gone;
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, hits_seen);
  endtask

  // sender: bursts of transfers separated by random gaps
  task automatic send_item(gdr_in_t it);
    int gap;
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (it.cmd == CMD_WRITE) begin
      writes_sent++;
      if (it.tile_x < MAP_DIM && it.tile_y < MAP_DIM) tiles[it.tile_y*MAP_DIM + it.tile_x] = it.tile_value;
    end else begin
      hit_queue.push_back(cast_ray(it));
      casts_sent++;
    end
    if ($urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (hit_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic gdr_in_t wr_item(int x, int y, int v);
    gdr_in_t it;
    it = '0;
    it.cmd = CMD_WRITE; it.tile_x = x; it.tile_y = y; it.tile_value = v;
    return it;
  endfunction

  function automatic gdr_in_t ray_item(int px, int py, int ddx, int ddy);
    gdr_in_t it;
    it = '0;
    it.cmd = CMD_CAST;
    it.pos_x = px; it.pos_y = py; it.dir_x = ddx; it.dir_y = ddy;
    it.tile_x = $urandom; it.tile_y = $urandom; it.tile_value = $urandom;
    return it;
  endfunction

  // receiver: stall pattern, plus one long hold-off while the sender keeps going
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (long_stall) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 9) > 2) || (hits_seen[6:5] == 2'b01);
  end

  always @(posedge clk) begin
    gdr_out_t want;
    if (!rst && out_valid && out_ready) begin
      hits_seen++;
      if (out_data.outside) outside_seen++;
      if (hit_queue.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        want = hit_queue.pop_front();
        if (out_data.hit_x != want.hit_x) report("hit_x", out_data.hit_x, want.hit_x);
        if (out_data.hit_y != want.hit_y) report("hit_y", out_data.hit_y, want.hit_y);
        if (out_data.hit_side != want.hit_side)
          report("hit_side", out_data.hit_side, want.hit_side);
        if (out_data.distance != want.distance)
          report("distance", out_data.distance, want.distance);
        if (out_data.outside != want.outside)
          report("outside", out_data.outside, want.outside);
      end
    end
  end

  // watchdog: count cycles without any transfer (reset clear pass included)
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles", idle_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  typedef struct {
    gdr_in_t  item;
    bit       known;
    gdr_out_t want;
  } dir_row_t;

  initial begin
    dir_row_t rows [$];
    dir_row_t row;
    gdr_in_t  it;
    gdr_out_t pred;
    int       n, k, kind, cx, cy;
    int       next_fill;
    bit       stall_done, mid_drained;

    for (int i = 0; i < MAP_DIM*MAP_DIM; i++) tiles[i] = 8'd0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed table: known rows are typed in; the rest use the predictor
    row.known = 1'b1;
    row.item = ray_item(22'h3FFFFF, 22'h3FFFFF, 0, 0);        // far corner, zero direction
    row.want = '{hit_x: 6'd0, hit_y: 6'd0, hit_side: 1'b0, distance: 24'd255, outside: 1'b1};
    rows.push_back(row);
    row.item = ray_item(64 << 16, 5 << 16, 1 << 16, 0);       // x wraps to 0, runs across
    row.want = '{hit_x: 6'd0, hit_y: 6'd5, hit_side: 1'b0, distance: 24'd4194304,
                 outside: 1'b1};
    rows.push_back(row);
    row.item = ray_item(0, 0, -524288, 0);                     // empty map, leave at -1
    row.want = '{hit_x: 6'd63, hit_y: 6'd0, hit_side: 1'b0, distance: 24'd0, outside: 1'b1};
    rows.push_back(row);
    row.known = 1'b0;
    row.item = wr_item(10, 5, 255); rows.push_back(row);
    row.item = wr_item(63, 63, 1); rows.push_back(row);
    row.item = wr_item(0, 0, 0); rows.push_back(row);
    row.item = ray_item(5 << 16, 5 << 16, 1 << 16, 0); rows.push_back(row);
    row.item = ray_item(32'h8000 | (5 << 16), 32'h8000 | (5 << 16), 524287, 524287);
    rows.push_back(row);
    row.item = ray_item(60 << 16, 60 << 16, 1 << 16, 1 << 16); rows.push_back(row); // tie
    row.item = ray_item(1 << 16, 1 << 16, 0, 0); rows.push_back(row);               // saturated
    row.item = ray_item(63 << 16 | 16'hFFFF, 0, 1, -1); rows.push_back(row);
    row.item = ray_item(30 << 16, 30 << 16, -524288, 524287); rows.push_back(row);
    row.item = ray_item(30 << 16, 40 << 16, 0, -1); rows.push_back(row);
    row.item = ray_item(2 << 16, 5 << 16, 3, 0); rows.push_back(row);               // tiny dir
    row.item = wr_item(10, 5, 0); rows.push_back(row);
    row.item = ray_item(5 << 16, 5 << 16, 1 << 16, 0); rows.push_back(row);

    foreach (rows[i]) begin
      if (rows[i].item.cmd == CMD_CAST) begin
        pred = cast_ray(rows[i].item);
        if (rows[i].known && pred != rows[i].want) report("directed row", i, 0);
      end
      send_item(rows[i].item);
    end
    drain();

    // random part: random casts among bursts of noise writes and periodic tile fills
    n = 0;
    next_fill = 300;
    stall_done = 1'b0;
    mid_drained = 1'b0;
    while (n < N_RANDOM) begin
      if ($urandom_range(0, 4) == 0) begin
        for (k = 0; k < 12; k++) begin
          it = wr_item($urandom, $urandom, ($urandom_range(0, 2) == 0) ? $urandom : 0);
          send_item(it);
          n++;
        end
      end
      kind = $urandom_range(0, 9);
      cx = $urandom_range(0, 63);
      cy = $urandom_range(0, 63);
      if (kind == 0) begin
        it = ray_item($urandom, $urandom, $urandom, $urandom);
      end else if (kind == 1) begin
        it = ray_item((cx << 16) | $urandom_range(0, 65535), (cy << 16) | $urandom_range(0, 65535),
                      $urandom_range(0, 1) ? 0 : $urandom, $urandom_range(0, 1) ? 0 : $urandom);
      end else begin
        it = ray_item((cx << 16) | $urandom_range(0, 65535), (cy << 16) | $urandom_range(0, 65535),
                      $signed($urandom_range(0, 262143)) - 131072,
                      $signed($urandom_range(0, 262143)) - 131072);
      end
      if (kind == 3) it = wr_item(cx, cy, $urandom_range(1, 255));
      send_item(it);
      n++;
      if (n >= 400 && !stall_done) begin
        stall_done = 1'b1;
        long_stall = 1'b1;
        fork
          begin
            repeat (3000) @(posedge clk);
            long_stall = 1'b0;
          end
        join_none
        for (k = 0; k < 6; k++) send_item(ray_item(cx << 16, cy << 16, 1 << 16, -(1 << 15)));
      end
      if (n >= 900 && !mid_drained) begin
        mid_drained = 1'b1;
        drain();
      end
      if (n >= next_fill) begin
        next_fill += 300;
        for (k = 0; k < MAP_DIM; k++) send_item(wr_item(k, $urandom, $urandom));
      end
    end
    drain();

    $display("Ran %0d casts and %0d tile writes; %0d results, %0d left the map",
             casts_sent, writes_sent, hits_seen, outside_seen);
    if (errors == 0 && hit_queue.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, hit_queue.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
